/* sv/obc_pkg.sv */
// Shared types, constants and symbol mapping functions for the offset byte
// base64url codec. No dependencies.
package obc_pkg;

    localparam int NUM_OFFSETS = 6;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [2:0] CFG_DIRECTION    = 3'd0;
    localparam logic [2:0] CFG_OFFSET_ZERO  = 3'd1;
    localparam logic [2:0] CFG_OFFSET_ONE   = 3'd2;
    localparam logic [2:0] CFG_OFFSET_TWO   = 3'd3;
    localparam logic [2:0] CFG_OFFSET_THREE = 3'd4;
    localparam logic [2:0] CFG_OFFSET_FOUR  = 3'd5;
    localparam logic [2:0] CFG_OFFSET_FIVE  = 3'd6;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;

    typedef struct packed {
        logic                             direction;
        logic [NUM_OFFSETS-1:0][7:0]      offset;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_result;
        logic       error_flag;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [7:0] sym_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = CHAR_DASH;
        end else begin
            c = CHAR_UNDER;
        end
        return c;
    endfunction

    // Bit 6 set marks a character outside both alphabets.
    function automatic logic [6:0] char_sym(input logic [7:0] c);
        logic [6:0] s;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s = {1'b0, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s = {1'b0, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s = {1'b0, 6'(c - 8'h30 + 8'd52)};
        end else if (c == CHAR_PLUS || c == CHAR_DASH) begin
            s = {1'b0, 6'd62};
        end else if (c == CHAR_SLASH || c == CHAR_UNDER) begin
            s = {1'b0, 6'd63};
        end else begin
            s = 7'h40;
        end
        return s;
    endfunction

endpackage

/* sv/obc_core.sv */
// Message state and single-pass encode/decode step of the codec.
// Depends on obc_pkg.
module obc_core
    import obc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       clear,
    input  logic       item_accept,
    input  logic [7:0] data_byte,
    input  logic       final_item,
    output push_t      push
);

    logic [2:0] pos_reg, pos_next;
    logic [1:0] phase_reg, phase_next;
    logic [5:0] buf_reg, buf_next;
    logic       pad_reg, pad_next;
    logic       err_reg, err_next;

    logic [2:0]  sel_pos;
    logic [2:0]  adv_pos;
    logic [7:0]  off;
    logic [7:0]  enc_b;
    logic [9:0]  buf10;
    logic [11:0] buf12;
    logic [5:0]  c0, c1;
    logic [6:0]  sym;
    logic        have;
    logic [7:0]  dec_b;

    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        buf_next   = buf_reg;
        pad_next   = pad_reg;
        err_next   = err_reg;
        push       = '0;
        enc_b      = '0;
        buf10      = '0;
        buf12      = '0;
        c0         = '0;
        c1         = '0;
        have       = 1'b0;
        dec_b      = '0;
        sym        = char_sym(data_byte);
        sel_pos    = (pos_reg < 3'd6) ? pos_reg : 3'd0;
        adv_pos    = (sel_pos >= 3'd5) ? 3'd0 : sel_pos + 3'd1;
        off        = cfg.offset[sel_pos];

        if (item_accept) begin
            if (cfg.direction == DIR_ENCODE) begin
                enc_b    = data_byte - off;
                pos_next = adv_pos;
                case (phase_reg)
                    2'd1:
                    begin
                        buf10      = {buf_reg[1:0], enc_b};
                        c0         = buf10[9:4];
                        c1         = {buf10[3:0], 2'b00};
                        buf_next   = {2'b00, buf10[3:0]};
                        phase_next = 2'd2;
                        push.count = final_item ? 2'd2 : 2'd1;
                    end
                    2'd2:
                    begin
                        buf12      = {buf_reg[3:0], enc_b};
                        c0         = buf12[11:6];
                        c1         = buf12[5:0];
                        buf_next   = '0;
                        phase_next = 2'd0;
                        push.count = 2'd2;
                    end
                    default:
                    begin
                        c0         = enc_b[7:2];
                        c1         = {enc_b[1:0], 4'b0000};
                        buf_next   = {4'b0000, enc_b[1:0]};
                        phase_next = 2'd1;
                        push.count = final_item ? 2'd2 : 2'd1;
                    end
                endcase
                push.first  = '{sym_char(c0), 1'b1, final_item && push.count == 2'd1, 1'b0};
                push.second = '{sym_char(c1), 1'b1, final_item, 1'b0};
            end else begin
                if (!err_reg) begin
                    if (data_byte == CHAR_PAD) begin
                        if (phase_reg < 2'd2) begin
                            err_next = 1'b1;
                        end else begin
                            pad_next   = 1'b1;
                            phase_next = phase_reg + 2'd1;
                        end
                    end else if (sym[6] || pad_reg) begin
                        err_next = 1'b1;
                    end else begin
                        case (phase_reg)
                            2'd0:
                            begin
                                buf_next = sym[5:0];
                            end
                            2'd1:
                            begin
                                buf12    = {buf_reg, sym[5:0]};
                                dec_b    = buf12[11:4];
                                buf_next = {2'b00, buf12[3:0]};
                                have     = 1'b1;
                            end
                            2'd2:
                            begin
                                buf10    = {buf_reg[3:0], sym[5:0]};
                                dec_b    = buf10[9:2];
                                buf_next = {4'b0000, buf10[1:0]};
                                have     = 1'b1;
                            end
                            default:
                            begin
                                dec_b    = {buf_reg[1:0], sym[5:0]};
                                buf_next = '0;
                                have     = 1'b1;
                            end
                        endcase
                        phase_next = phase_reg + 2'd1;
                    end
                end
                if (have) begin
                    dec_b    = dec_b + off;
                    pos_next = adv_pos;
                end
                if (!final_item) begin
                    push.first = '{dec_b, 1'b1, 1'b0, 1'b0};
                    push.count = have ? 2'd1 : 2'd0;
                end else begin
                    if (!err_next) begin
                        if (pad_next && phase_next != 2'd0) begin
                            err_next = 1'b1;
                        end
                        if (!pad_next && phase_next == 2'd1) begin
                            err_next = 1'b1;
                        end
                    end
                    if (err_next || !have) begin
                        push.first = '{8'h00, 1'b0, 1'b1, err_next};
                    end else begin
                        push.first = '{dec_b, 1'b1, 1'b1, 1'b0};
                    end
                    push.count = 2'd1;
                end
            end
            if (final_item) begin
                pos_next   = '0;
                phase_next = '0;
                buf_next   = '0;
                pad_next   = 1'b0;
                err_next   = 1'b0;
            end
        end

        if (clear) begin
            pos_next   = '0;
            phase_next = '0;
            buf_next   = '0;
            pad_next   = 1'b0;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg   <= '0;
            phase_reg <= '0;
            buf_reg   <= '0;
            pad_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            buf_reg   <= buf_next;
            pad_reg   <= pad_next;
            err_reg   <= err_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < 3'd6)
        else $error("byte position left its range");

    a_encode_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && cfg.direction == DIR_ENCODE) |->
            (!push.first.error_flag && !push.second.error_flag))
        else $error("encoding raised an error flag");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && final_item) |=> (phase_reg == 2'd0 && !err_reg && !pad_reg))
        else $error("message state not cleared after the final beat");

    a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && final_item) |->
            (push.count == 2'd1 ? push.first.last_result
                                : (push.second.last_result && !push.first.last_result)))
        else $error("final beat must carry exactly one last result");

endmodule

/* sv/obc_fifo.sv */
// Small result queue taking up to two results per cycle and giving one per
// cycle while out_ready is high. Depends on obc_pkg.
module obc_fifo
    import obc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    space_two,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t head
);

    result_t                entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_reg, wr_next;
    logic [FIFO_PTR_W-1:0]  rd_reg, rd_next;
    logic [FIFO_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                   pop;

    assign out_valid = (cnt_reg != '0);
    assign head      = entry_reg[rd_reg];
    assign space_two = (cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_next  = wr_reg + FIFO_PTR_W'(push.count);
        rd_next  = rd_reg + FIFO_PTR_W'(pop);
        cnt_next = cnt_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0) begin
            entry_reg[wr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_reg + FIFO_PTR_W'(1)] <= push.second;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> space_two)
        else $error("results pushed without room for two");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.count == 2'd0) |=> (cnt_reg == $past(cnt_reg) - FIFO_CNT_W'(1)))
        else $error("queue count did not drop after a beat left");

endmodule

/* sv/offset_byte_base64url_codec.sv */
// Top level of the offset byte base64url codec: register file, core, result queue.
// Depends on obc_pkg, obc_core and obc_fifo.
//
//   Channel  Direction  Beat contents
//   in       sink       data_byte, final_item
//   out      source     out_byte, byte_valid, last_result, error_flag
//   cfg      sink       cfg_index, cfg_data (always ready)
//
// An input beat is processed in the cycle it is accepted and its zero, one or two
// results are queued; results leave one per cycle while out_ready is high.
// One result per beat then sustains one beat per cycle; two fill the queue.
// in_ready is high while the four-entry result queue has room for two results.
// Reset clears the message state, the queue and the registers to their defaults.
module offset_byte_base64url_codec
    import obc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       final_item,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last_result,
    output logic       error_flag,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    cfg_write;
    logic    clear;
    logic    item_accept;
    push_t   push;
    result_t head;

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign clear       = cfg_write && (cfg_index == CFG_DIRECTION);
    assign item_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.direction <= DIR_ENCODE;
            cfg_reg.offset[0] <= 8'd1;
            cfg_reg.offset[1] <= 8'd5;
            cfg_reg.offset[2] <= 8'd7;
            cfg_reg.offset[3] <= 8'd2;
            cfg_reg.offset[4] <= 8'd4;
            cfg_reg.offset[5] <= 8'd9;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_DIRECTION:    cfg_reg.direction <= cfg_data[0];
                CFG_OFFSET_ZERO:  cfg_reg.offset[0] <= cfg_data;
                CFG_OFFSET_ONE:   cfg_reg.offset[1] <= cfg_data;
                CFG_OFFSET_TWO:   cfg_reg.offset[2] <= cfg_data;
                CFG_OFFSET_THREE: cfg_reg.offset[3] <= cfg_data;
                CFG_OFFSET_FOUR:  cfg_reg.offset[4] <= cfg_data;
                CFG_OFFSET_FIVE:  cfg_reg.offset[5] <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    obc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .clear       (clear),
        .item_accept (item_accept),
        .data_byte   (data_byte),
        .final_item  (final_item),
        .push        (push)
    );

    obc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_two (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign out_byte    = head.out_byte;
    assign byte_valid  = head.byte_valid;
    assign last_result = head.last_result;
    assign error_flag  = head.error_flag;

endmodule

/* bench/offset_byte_base64url_codec_test.sv */
// Self-checking testbench for the offset byte base64url codec: it sends whole messages in
// both directions under several register settings and pacing patterns, and checks every
// output beat against its own model of the codec. Depends on obc_pkg and the codec top level.
module offset_byte_base64url_codec_test;
    import obc_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 2000;
    localparam logic [8*64-1:0] URL_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte  = 8'h00;
    logic       final_item = 1'b0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_result;
    logic       error_flag;
    logic       cfg_valid  = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index  = CFG_DIRECTION;
    logic [7:0] cfg_data   = 8'h00;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int failures       = 0;
    int idle_cycles    = 0;
    int items_sent     = 0;

    logic        dir_reg = DIR_ENCODE;
    logic [7:0]  offset_reg [NUM_OFFSETS] = '{8'd1, 8'd5, 8'd7, 8'd2, 8'd4, 8'd9};
    logic [2:0]  stream_pos  = '0;
    logic [1:0]  group_phase = '0;
    logic [23:0] bit_store   = '0;
    logic        pad_seen    = 1'b0;
    logic        dec_error   = 1'b0;
    result_t     awaited_outputs [$];
    logic [7:0]  message_q [$];

    offset_byte_base64url_codec u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .final_item  (final_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .last_result (last_result),
        .error_flag  (error_flag),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [7:0] url_char(input logic [5:0] v);
        return URL_ALPHABET[8*(63 - int'(v)) +: 8];
    endfunction

    function automatic logic [7:0] random_text_char();
        logic [5:0] v;
        v = 6'($urandom_range(63));
        if (v == 6'd62 && $urandom_range(1) == 1)
        begin
            return CHAR_PLUS;
        end
        if (v == 6'd63 && $urandom_range(1) == 1)
        begin
            return CHAR_SLASH;
        end
        return url_char(v);
    endfunction

    function automatic void clear_stream_state();
        stream_pos  = '0;
        group_phase = '0;
        bit_store   = '0;
        pad_seen    = 1'b0;
        dec_error   = 1'b0;
    endfunction

    function automatic logic [7:0] take_offset();
        logic [7:0] o;
        o = offset_reg[stream_pos];
        stream_pos = (stream_pos == 3'(NUM_OFFSETS - 1)) ? 3'd0 : stream_pos + 3'd1;
        return o;
    endfunction

    function automatic void expect_beat(input logic [7:0] b, input logic valid,
                                        input logic last, input logic err);
        result_t r;
        r.out_byte    = b;
        r.byte_valid  = valid;
        r.last_result = last;
        r.error_flag  = err;
        awaited_outputs.push_back(r);
    endfunction

    // Advances the codec state by one accepted input beat and queues the output beats
    // that it must produce.
    function automatic void predict_codec_beat(input logic [7:0] d, input logic fin);
        logic [6:0] sym;
        logic [7:0] value;
        logic [5:0] first_sym;
        logic [5:0] second_sym;
        logic       full_group;
        logic       have;
        int         k;
        sym        = 7'h40;
        value      = 8'h00;
        first_sym  = '0;
        second_sym = '0;
        have       = 1'b0;
        full_group = (group_phase == 2'd2);
        if (dir_reg == DIR_ENCODE)
        begin
            value = d - take_offset();
            case (group_phase)
                2'd0:
                begin
                    first_sym   = value[7:2];
                    second_sym  = {value[1:0], 4'b0000};
                    bit_store   = {22'd0, value[1:0]};
                    group_phase = 2'd1;
                end
                2'd1:
                begin
                    first_sym   = {bit_store[1:0], value[7:4]};
                    second_sym  = {value[3:0], 2'b00};
                    bit_store   = {20'd0, value[3:0]};
                    group_phase = 2'd2;
                end
                default:
                begin
                    first_sym   = {bit_store[3:0], value[7:6]};
                    second_sym  = value[5:0];
                    bit_store   = '0;
                    group_phase = 2'd0;
                end
            endcase
            if (full_group || fin)
            begin
                expect_beat(url_char(first_sym), 1'b1, 1'b0, 1'b0);
                expect_beat(url_char(second_sym), 1'b1, fin, 1'b0);
            end
            else
            begin
                expect_beat(url_char(first_sym), 1'b1, 1'b0, 1'b0);
            end
            if (fin)
            begin
                clear_stream_state();
            end
        end
        else
        begin
            for (k = 0; k < 64; k++)
            begin
                if (url_char(6'(k)) == d)
                begin
                    sym = 7'(k);
                end
            end
            if (d == CHAR_PLUS)
            begin
                sym = 7'd62;
            end
            if (d == CHAR_SLASH)
            begin
                sym = 7'd63;
            end
            if (!dec_error)
            begin
                if (d == CHAR_PAD)
                begin
                    if (group_phase < 2'd2)
                    begin
                        dec_error = 1'b1;
                    end
                    else
                    begin
                        pad_seen    = 1'b1;
                        group_phase = group_phase + 2'd1;
                    end
                end
                else if (sym[6] || pad_seen)
                begin
                    dec_error = 1'b1;
                end
                else
                begin
                    case (group_phase)
                        2'd0:
                        begin
                            bit_store = {18'd0, sym[5:0]};
                        end
                        2'd1:
                        begin
                            value     = {bit_store[5:0], sym[5:4]};
                            bit_store = {20'd0, sym[3:0]};
                            have      = 1'b1;
                        end
                        2'd2:
                        begin
                            value     = {bit_store[3:0], sym[5:2]};
                            bit_store = {22'd0, sym[1:0]};
                            have      = 1'b1;
                        end
                        default:
                        begin
                            value     = {bit_store[1:0], sym[5:0]};
                            bit_store = '0;
                            have      = 1'b1;
                        end
                    endcase
                    group_phase = group_phase + 2'd1;
                end
            end
            if (have)
            begin
                value = value + take_offset();
            end
            if (!fin)
            begin
                if (have)
                begin
                    expect_beat(value, 1'b1, 1'b0, 1'b0);
                end
            end
            else
            begin
                if (pad_seen && group_phase != 2'd0)
                begin
                    dec_error = 1'b1;
                end
                if (!pad_seen && group_phase == 2'd1)
                begin
                    dec_error = 1'b1;
                end
                if (dec_error || !have)
                begin
                    expect_beat(8'h00, 1'b0, 1'b1, dec_error);
                end
                else
                begin
                    expect_beat(value, 1'b1, 1'b1, 1'b0);
                end
                clear_stream_state();
            end
        end
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            failures++;
        end
    endfunction

    // Sampled on the falling edge, where the handshake that completes on the next rising
    // edge is already settled.
    always @(negedge clk)
    begin : check_outputs
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_outputs.size() == 0)
            begin
                $display("%0t: unexpected beat: expected none, actual %h %b %b %b", $time,
                         out_byte, byte_valid, last_result, error_flag);
                failures++;
            end
            else
            begin
                want = awaited_outputs.pop_front();
                compare_field("out_byte", want.out_byte, out_byte);
                compare_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid));
                compare_field("last_result", 8'(want.last_result), 8'(last_result));
                compare_field("error_flag", 8'(want.error_flag), 8'(error_flag));
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("** offset_byte_base64url_codec: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [7:0] d, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= d;
        final_item <= fin;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_codec_beat(d, fin);
        items_sent++;
    endtask

    task automatic send_message();
        int k;
        for (k = 0; k < message_q.size(); k++)
        begin
            send_item(message_q[k], k == message_q.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        int k;
        message_q.delete();
        for (k = 0; k < s.len(); k++)
        begin
            message_q.push_back(s[k]);
        end
        send_message();
    endtask

    // Lets a beat that produces no output finish inside the codec before the next
    // register write.
    task automatic finish_phase();
        in_valid <= 1'b0;
        while (awaited_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        if (idx == CFG_DIRECTION)
        begin
            dir_reg = value[0];
            clear_stream_state();
        end
        else
        begin
            offset_reg[idx - CFG_OFFSET_ZERO] = value;
        end
        @(posedge clk);
    endtask

    task automatic configure(input logic dir, input logic pick_random,
                             input logic [7:0] fixed_offset);
        int k;
        write_register(CFG_DIRECTION, {7'd0, dir});
        for (k = 0; k < NUM_OFFSETS; k++)
        begin
            write_register(CFG_OFFSET_ZERO + 3'(k),
                           pick_random ? 8'($urandom_range(255)) : fixed_offset);
        end
    endtask

    // Decode messages are mostly well formed, with random content; about a quarter carry
    // a stray byte, a misplaced pad, a lone final character or an extra pad.
    task automatic run_random_messages(input int budget);
        int stop_at;
        int length;
        int kind;
        int spot;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            message_q.delete();
            if (dir_reg == DIR_ENCODE)
            begin
                length = ($urandom_range(9) == 0) ? $urandom_range(24, 12)
                                                  : $urandom_range(6, 1);
                repeat (length) message_q.push_back(8'($urandom_range(255)));
            end
            else
            begin
                length = $urandom_range(16, 2);
                if (length % 4 == 1)
                begin
                    length++;
                end
                repeat (length) message_q.push_back(random_text_char());
                if (length % 4 != 0 && $urandom_range(1) == 1)
                begin
                    repeat (4 - length % 4) message_q.push_back(CHAR_PAD);
                end
                kind = $urandom_range(99);
                spot = $urandom_range(message_q.size() - 1);
                if (kind < 6)
                begin
                    message_q[spot] = 8'($urandom_range(255));
                end
                else if (kind < 12)
                begin
                    message_q.insert(spot, CHAR_PAD);
                end
                else if (kind < 18)
                begin
                    while (message_q.size() > 4 * (spot / 4) + 1)
                    begin
                        void'(message_q.pop_back());
                    end
                end
                else if (kind < 24)
                begin
                    message_q.push_back(CHAR_PAD);
                end
            end
            send_message();
        end
    endtask

    task automatic test_encode_reset_values();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        message_q = '{8'h00};
        send_message();
        message_q = '{8'hFF, 8'h80};
        send_message();
        message_q = '{8'h00, 8'hFF, 8'h7F};
        send_message();
        finish_phase();
    endtask

    task automatic test_decode_special_cases();
        configure(DIR_DECODE, 1'b1, 8'h00);
        send_text("-_+/AB===");
        send_text("=");
        send_text("A=");
        send_text("AB=C");
        send_text("AB=");
        send_text("A*");
        send_text("A");
        finish_phase();
    endtask

    task automatic test_offset_extremes();
        int m;
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        for (m = 0; m < 4; m++)
        begin
            configure((m % 2 == 1) ? DIR_DECODE : DIR_ENCODE, 1'b0,
                      (m < 2) ? 8'h00 : 8'hFF);
            run_random_messages(30);
            finish_phase();
        end
    endtask

    task automatic run_paced_phase(input int idle_pct, input int stall_pct);
        int k;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (k = 0; k < 2; k++)
        begin
            configure((k == 1) ? DIR_DECODE : DIR_ENCODE, 1'b1, 8'h00);
            run_random_messages(100);
            finish_phase();
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_encode_reset_values();
        test_decode_special_cases();
        test_offset_extremes();
        run_paced_phase(0, 0);
        run_paced_phase(85, 0);
        run_paced_phase(0, 85);
        run_paced_phase(10, 10);
        if (failures == 0 && awaited_outputs.size() == 0)
        begin
            $display("** offset_byte_base64url_codec: PASSED **");
        end
        else
        begin
            $display("** offset_byte_base64url_codec: FAILED **");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/obc_pkg.sv
sv/obc_core.sv
sv/obc_fifo.sv
sv/offset_byte_base64url_codec.sv
bench/offset_byte_base64url_codec_test.sv
